FILE: rtl/aafi_pkg.sv
package aafi_pkg;

    // data type codes carried in the mode field
    localparam logic [3:0] MODE_FLOAT  = 4'd0;
    localparam logic [3:0] MODE_DOUBLE = 4'd1;
    localparam logic [3:0] MODE_INT32  = 4'd2;
    localparam logic [3:0] MODE_INT64  = 4'd3;
    localparam logic [3:0] MODE_INT8   = 4'd4;
    localparam logic [3:0] MODE_INT1   = 4'd5;
    localparam logic [3:0] MODE_INT16  = 4'd6;
    localparam logic [3:0] MODE_HALF   = 4'd7;

    // aggressiveness codes, anything else behaves as mild
    localparam logic [1:0] LEVEL_MILD       = 2'd1;
    localparam logic [1:0] LEVEL_MEDIUM     = 2'd2;
    localparam logic [1:0] LEVEL_AGGRESSIVE = 2'd3;

    // configuration register indexes
    localparam logic [2:0] CFG_ALU_ENABLE   = 3'd0;
    localparam logic [2:0] CFG_LEVEL        = 3'd1;
    localparam logic [2:0] CFG_BYTE_COUNT   = 3'd2;
    localparam logic [2:0] CFG_SEED         = 3'd3;
    localparam logic [2:0] CFG_THR_MILD     = 3'd4;
    localparam logic [2:0] CFG_THR_MEDIUM   = 3'd5;
    localparam logic [2:0] CFG_THR_AGGR     = 3'd6;

    // reset values
    localparam logic [63:0] SEED_RESET     = 64'd12345;
    localparam logic [63:0] THR_MILD_RESET = 64'd18446744073710;
    localparam logic [63:0] THR_MED_RESET  = 64'd1844674407370955;
    localparam logic [63:0] THR_AGGR_RESET = 64'd184467440737095516;

    // mantissa bits cleared per level
    localparam logic [5:0] FLOAT_DROP_MILD  = 6'd7;
    localparam logic [5:0] FLOAT_DROP_MED   = 6'd15;
    localparam logic [5:0] FLOAT_DROP_AGGR  = 6'd19;
    localparam logic [5:0] DOUBLE_DROP_MILD = 6'd20;
    localparam logic [5:0] DOUBLE_DROP_MED  = 6'd36;
    localparam logic [5:0] DOUBLE_DROP_AGGR = 6'd44;

    typedef struct packed {
        logic        alu_enable;
        logic [1:0]  level;
        logic [3:0]  byte_count;
        logic [63:0] thr_mild;
        logic [63:0] thr_medium;
        logic [63:0] thr_aggr;
    } t_cfg;

    // one 21/35/4 xorshift step
    function automatic logic [63:0] xorshift64(input logic [63:0] x);
        logic [63:0] a;
        logic [63:0] b;
        a = x ^ (x >> 21);
        b = a ^ (a << 35);
        return b ^ (b >> 4);
    endfunction

    // size of the data type in bytes, unknown codes are zero
    function automatic logic [3:0] type_size(input logic [3:0] mode);
        logic [3:0] s;
        unique case (mode)
            MODE_FLOAT:  s = 4'd4;
            MODE_DOUBLE: s = 4'd8;
            MODE_INT32:  s = 4'd4;
            MODE_INT64:  s = 4'd8;
            MODE_INT8:   s = 4'd1;
            MODE_INT1:   s = 4'd1;
            MODE_INT16:  s = 4'd2;
            MODE_HALF:   s = 4'd2;
            default:     s = 4'd0;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/approximate_alu_fault_injector_unit.sv
// approximate alu fault injector
//
// slave stream: i_s_tdata carries the raw 64-bit alu result, i_s_tuser the
// 4-bit data type code. master stream: o_m_tdata carries the degraded result.
// config channel: i_cfg_valid / o_cfg_ready with a 3-bit register index and
// 64-bit data; o_cfg_ready is always high. writes are to be made while idle
// only; the block itself does not enforce it.
// pipeline: a taken beat sits in the input register, passes the combinational
// generator step (two chained xorshift steps, a compare and a byte merge) and
// lands in the result register that drives the master side. throughput is one
// beat per cycle while the receiver does not stall; each register holds a beat.
//
// when the receiver stalls the result register holds its beat; the input
// register still takes one more beat, then o_s_tready drops until the
// master side moves again. the generator advances only when a beat moves
// from the input register into the result register.
//
// reset (synchronous, active low) empties both registers, restores every
// configuration register and loads the generator with the default seed.
module approximate_alu_fault_injector_unit
    import aafi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] value
    input  logic [3:0]  i_s_tuser,   // [3:0] mode
    // master stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // [63:0] result
    // configuration writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    t_cfg        r_cfg;
    logic [63:0] r_gen;
    logic        r_in_valid;
    logic [3:0]  r_mode;
    logic [63:0] r_value;
    logic        r_out_valid;
    logic [63:0] r_result;

    logic        w_out_free;
    logic        w_fire;
    logic        w_s_accept;
    logic        w_cfg_wr;
    logic [63:0] w_result;
    logic [63:0] w_gen_next;

    // result register free, or emptied in this cycle
    assign w_out_free = !r_out_valid || i_m_tready;
    // beat moves from the input register to the result register
    assign w_fire     = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_s_accept = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid;

    aafi_datapath u_datapath (
        .i_mode     (r_mode),
        .i_value    (r_value),
        .i_gen      (r_gen),
        .i_cfg      (r_cfg),
        .o_result   (w_result),
        .o_gen_next (w_gen_next)
    );

    // configuration registers and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.alu_enable <= 1'b0;
            r_cfg.level      <= LEVEL_MILD;
            r_cfg.byte_count <= 4'd0;
            r_cfg.thr_mild   <= THR_MILD_RESET;
            r_cfg.thr_medium <= THR_MED_RESET;
            r_cfg.thr_aggr   <= THR_AGGR_RESET;
            r_gen            <= SEED_RESET;
        end else begin
            if (w_fire) begin
                r_gen <= w_gen_next;
            end
            if (w_cfg_wr) begin
                unique case (i_cfg_index)
                    CFG_ALU_ENABLE: r_cfg.alu_enable <= i_cfg_data[0];
                    CFG_LEVEL:      r_cfg.level      <= i_cfg_data[1:0];
                    CFG_BYTE_COUNT: r_cfg.byte_count <= i_cfg_data[3:0];
                    CFG_SEED:       r_gen            <= i_cfg_data;
                    CFG_THR_MILD:   r_cfg.thr_mild   <= i_cfg_data;
                    CFG_THR_MEDIUM: r_cfg.thr_medium <= i_cfg_data;
                    CFG_THR_AGGR:   r_cfg.thr_aggr   <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_s_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s_accept) begin
            r_mode  <= i_s_tuser;
            r_value <= i_s_tdata;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_result;

endmodule

FILE: rtl/aafi_datapath.sv
module aafi_datapath
    import aafi_pkg::*;
(
    input  logic [3:0]  i_mode,
    input  logic [63:0] i_value,
    input  logic [63:0] i_gen,
    input  t_cfg        i_cfg,
    output logic [63:0] o_result,
    output logic [63:0] o_gen_next
);

    logic [63:0] w_first;
    logic [63:0] w_second;
    logic [63:0] w_thr;
    logic [5:0]  w_drop;
    logic [63:0] w_fp_mask;
    logic        w_is_fp;
    logic        w_hit;
    logic [3:0]  w_size;
    logic [3:0]  w_nbytes;
    logic [63:0] w_byte_mask;

    assign w_first  = xorshift64(i_gen);
    assign w_second = xorshift64(w_first);
    assign w_is_fp  = (i_mode == MODE_FLOAT) || (i_mode == MODE_DOUBLE);

    // per-level threshold and mantissa cut
    always_comb begin
        unique case (i_cfg.level)
            LEVEL_MEDIUM: begin
                w_thr  = i_cfg.thr_medium;
                w_drop = (i_mode == MODE_DOUBLE) ? DOUBLE_DROP_MED : FLOAT_DROP_MED;
            end
            LEVEL_AGGRESSIVE: begin
                w_thr  = i_cfg.thr_aggr;
                w_drop = (i_mode == MODE_DOUBLE) ? DOUBLE_DROP_AGGR : FLOAT_DROP_AGGR;
            end
            default: begin
                w_thr  = i_cfg.thr_mild;
                w_drop = (i_mode == MODE_DOUBLE) ? DOUBLE_DROP_MILD : FLOAT_DROP_MILD;
            end
        endcase
    end

    assign w_fp_mask = {64{1'b1}} << w_drop;
    assign w_hit     = w_first < w_thr;
    assign w_size    = type_size(i_mode);
    assign w_nbytes  = (i_cfg.byte_count < w_size) ? i_cfg.byte_count : w_size;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            w_byte_mask[8*k +: 8] = {8{4'(k) < w_nbytes}};
        end
    end

    always_comb begin
        if (!i_cfg.alu_enable) begin
            o_result   = i_value;
            o_gen_next = i_gen;
        end else if (w_is_fp) begin
            o_result   = i_value & w_fp_mask;
            o_gen_next = w_first;
        end else if (w_hit) begin
            o_result   = (i_value & ~w_byte_mask) | (w_second & w_byte_mask);
            o_gen_next = w_second;
        end else begin
            o_result   = i_value;
            o_gen_next = w_first;
        end
    end

endmodule

FILE: rtl/aafi_checker.sv
module aafi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result beat present after reset");

    // a stalled result beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result beat changed or dropped");

    // the slave side only stalls behind a stalled result beat
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> o_m_tvalid && !i_m_tready)
        else $error("slave side stalled without a stalled result");

    // a beat taken while the master side is empty shows up on it via the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && !o_m_tvalid && i_m_tready |=> ##1 o_m_tvalid)
        else $error("result beat missing after accepted input");

endmodule

bind approximate_alu_fault_injector_unit aafi_checker u_aafi_checker (.*);
